// File: rtl/led_pkg.sv
// Shared types and codes for the Levenshtein edit distance block.
// Used by led_cell, levenshtein_edit_distance and led_checker.
package led_pkg;

  localparam int SYM_W  = 8;
  localparam int DIST_W = 9;
  localparam int OP_W   = 2;
  localparam int DIST_MAX = 511;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FEED   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_FEED   = 2'd1,
    TOK_FINISH = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [SYM_W-1:0] sym;
  } tok_ctl_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] sym;
  } load_t;

endpackage

// File: rtl/led_cell.sv
// One cell of the edit distance array: holds one byte of the first string
// and its table entry. Depends on led_pkg.
module led_cell #(
  parameter int MAX_LEN = 256,
  parameter int IDX     = 0
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  led_pkg::load_t                               load_i,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] load_idx_i,
  input  led_pkg::tok_ctl_t                            ctl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 left_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 diag_i,
  output led_pkg::tok_ctl_t                            ctl_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                 left_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                 diag_o
);

  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [DW-1:0] POS = DW'(IDX + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                        valid_r, valid_nxt;
  logic [led_pkg::SYM_W-1:0]   pat_r, pat_nxt;
  logic [DW-1:0]               val_r, val_nxt;
  led_pkg::tok_ctl_t           ctl_r;
  logic [DW-1:0]               left_r, left_nxt;
  logic [DW-1:0]               diag_r, diag_nxt;

  logic          hit, is_feed, is_fin;
  logic [DW:0]   up_c, left_c, sub_c, min_a, min_b;
  logic [DW-1:0] cand;

  always_comb begin
    hit     = load_i.en && (load_idx_i == MY_IDX);
    is_feed = (ctl_i.kind == led_pkg::TOK_FEED);
    is_fin  = (ctl_i.kind == led_pkg::TOK_FINISH);
    up_c    = {1'b0, val_r} + (DW+1)'(1);
    left_c  = {1'b0, left_i} + (DW+1)'(1);
    sub_c   = {1'b0, diag_i} + (DW+1)'(pat_r != ctl_i.sym);
    min_a   = (up_c < left_c) ? up_c : left_c;
    min_b   = (min_a < sub_c) ? min_a : sub_c;
    cand    = min_b[DW-1:0];

    pat_nxt   = hit ? load_i.sym : pat_r;
    valid_nxt = valid_r;
    val_nxt   = val_r;
    priority if (hit) begin
      valid_nxt = 1'b1;
      val_nxt   = POS;
    end else if (is_fin) begin
      valid_nxt = 1'b0;
    end else if (is_feed && valid_r) begin
      val_nxt = cand;
    end

    if (valid_r) begin
      left_nxt = is_feed ? cand : val_r;
      diag_nxt = val_r;
    end else begin
      left_nxt = left_i;
      diag_nxt = diag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      ctl_r     <= '{kind: led_pkg::TOK_NONE, sym: '0};
    end else begin
      valid_r   <= valid_nxt;
      ctl_r     <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    val_r  <= val_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
  end

  assign ctl_o  = ctl_r;
  assign left_o = left_r;
  assign diag_o = diag_r;

endmodule

// File: rtl/levenshtein_edit_distance.sv
// Top level of the Levenshtein edit distance block: input decode, array of
// led_cell instances, result register with one skid slot. Depends on led_pkg.
//
// Channel | Dir | tdata                         | tuser
// in_     | in  | [7:0] symbol                  | [1:0] op
// out_    | out | [8:0] distance, [9] overflow  | -
//
// Append and feed transfers are taken one per cycle while input is not
// blocked; a feed byte crosses the cell array one cell per cycle as a
// wavefront. A finish transfer blocks input until its token has crossed
// the array, then the result enters the output register or the skid slot.
// A waiting result does not block input; a second waiting result does.
// Reset clears lengths, cell valid bits and the result slots.
module levenshtein_edit_distance #(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [8:0] distance, [9] overflow
);

  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [DW-1:0] LEN_FULL = DW'(MAX_LEN);

  typedef struct packed {
    logic [led_pkg::DIST_W-1:0] distance;
    logic                       overflow;
  } result_t;

  logic [DW-1:0]     plen_r, plen_nxt;
  logic [DW-1:0]     tlen_r, tlen_nxt;
  logic              drop_r, drop_nxt;
  logic              hold_ovf_r, hold_ovf_nxt;
  logic              busy_r, busy_nxt;

  led_pkg::tok_ctl_t src_ctl_r, src_ctl_nxt;
  logic [DW-1:0]     src_left_r, src_left_nxt;
  logic [DW-1:0]     src_diag_r, src_diag_nxt;

  led_pkg::load_t    load;
  logic [IW-1:0]     load_idx;

  led_pkg::tok_ctl_t ctl_w  [0:MAX_LEN];
  logic [DW-1:0]     left_w [0:MAX_LEN];
  logic [DW-1:0]     diag_w [0:MAX_LEN];

  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;
  logic              skid_full_r, skid_full_nxt;
  result_t           skid_r, skid_nxt;

  logic              in_xfer, exit_valid, out_take, sat;
  result_t           exit_data;
  led_pkg::op_t      op;

  assign op        = led_pkg::op_t'(in_tuser);
  assign in_tready = rst_n && !busy_r && !skid_full_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    plen_nxt     = plen_r;
    tlen_nxt     = tlen_r;
    drop_nxt     = drop_r;
    hold_ovf_nxt = hold_ovf_r;
    busy_nxt     = busy_r;
    src_ctl_nxt  = '{kind: led_pkg::TOK_NONE, sym: in_tdata};
    src_left_nxt = tlen_r;
    src_diag_nxt = tlen_r;
    load         = '{en: 1'b0, sym: in_tdata};
    load_idx     = plen_r[IW-1:0];

    if (ctl_w[MAX_LEN].kind == led_pkg::TOK_FINISH) begin
      busy_nxt = 1'b0;
    end

    if (in_xfer) begin
      unique case (op)
        led_pkg::OP_APPEND: begin
          if (plen_r == LEN_FULL || tlen_r != '0) begin
            drop_nxt = 1'b1;
          end else begin
            load.en  = 1'b1;
            plen_nxt = plen_r + DW'(1);
          end
        end
        led_pkg::OP_FEED: begin
          if (tlen_r == LEN_FULL) begin
            drop_nxt = 1'b1;
          end else begin
            tlen_nxt         = tlen_r + DW'(1);
            src_ctl_nxt.kind = led_pkg::TOK_FEED;
            src_left_nxt     = tlen_r + DW'(1);
          end
        end
        led_pkg::OP_FINISH: begin
          src_ctl_nxt.kind = led_pkg::TOK_FINISH;
          hold_ovf_nxt     = drop_r;
          busy_nxt         = 1'b1;
          plen_nxt         = '0;
          tlen_nxt         = '0;
          drop_nxt         = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= '0;
      tlen_r    <= '0;
      drop_r    <= 1'b0;
      busy_r    <= 1'b0;
      src_ctl_r <= '{kind: led_pkg::TOK_NONE, sym: '0};
    end else begin
      plen_r    <= plen_nxt;
      tlen_r    <= tlen_nxt;
      drop_r    <= drop_nxt;
      busy_r    <= busy_nxt;
      src_ctl_r <= src_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_ovf_r <= hold_ovf_nxt;
    src_left_r <= src_left_nxt;
    src_diag_r <= src_diag_nxt;
  end

  assign ctl_w[0]  = src_ctl_r;
  assign left_w[0] = src_left_r;
  assign diag_w[0] = src_diag_r;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    led_cell #(
      .MAX_LEN (MAX_LEN),
      .IDX     (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_i     (load),
      .load_idx_i (load_idx),
      .ctl_i      (ctl_w[g]),
      .left_i     (left_w[g]),
      .diag_i     (diag_w[g]),
      .ctl_o      (ctl_w[g+1]),
      .left_o     (left_w[g+1]),
      .diag_o     (diag_w[g+1])
    );
  end

  always_comb begin
    exit_valid         = (ctl_w[MAX_LEN].kind == led_pkg::TOK_FINISH);
    sat                = 32'(left_w[MAX_LEN]) > 32'(led_pkg::DIST_MAX);
    exit_data.distance = sat ? led_pkg::DIST_W'(led_pkg::DIST_MAX)
                             : led_pkg::DIST_W'(left_w[MAX_LEN]);
    exit_data.overflow = hold_ovf_r;
    out_take           = out_valid_r && out_tready;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_nxt      = skid_r;
    if (!out_valid_r || out_take) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = skid_r;
        skid_full_nxt = exit_valid;
        skid_nxt      = exit_data;
      end else begin
        out_valid_nxt = exit_valid;
        out_data_nxt  = exit_data;
      end
    end else if (exit_valid) begin
      skid_full_nxt = 1'b1;
      skid_nxt      = exit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r.overflow, out_data_r.distance};

endmodule

// File: rtl/led_checker.sv
// Port-level checks for levenshtein_edit_distance, attached by bind.
// Depends on led_pkg.
module led_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == led_pkg::OP_FINISH) |=> !in_tready)
    else $error("input taken while finish token in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:10] == 6'd0))
    else $error("padding bits of result not zero");

endmodule

bind levenshtein_edit_distance led_checker u_led_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
